### sv/mcc_pkg.sv
package mcc_pkg;

  localparam int SampleW         = 16;
  localparam int ColorW          = 24;
  localparam int WinW            = 64;
  localparam int CfgIdxW         = 3;
  localparam int MaxChannels     = 4;
  localparam int ChannelsDef     = 4;
  localparam int SampleBitsDef   = 16;
  localparam int CompW           = 8;
  localparam int SumW            = 10;
  // Lane stages: prepare, eight quotient bits, color product, divide by 255.
  localparam int LaneDepth       = 11;
  localparam int PipeDepth       = LaneDepth + 1;

  localparam logic [WinW-1:0]   WinReset   = 64'hFFFF_0000_FFFF_0000;
  localparam logic [ColorW-1:0] ColorReset = '0;

  typedef enum logic [CfgIdxW-1:0] {
    RegColorCh0  = 3'd0,
    RegColorCh1  = 3'd1,
    RegColorCh2  = 3'd2,
    RegColorCh3  = 3'd3,
    RegWindowCh01 = 3'd4,
    RegWindowCh23 = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [CompW-1:0] r;
    logic [CompW-1:0] g;
    logic [CompW-1:0] b;
  } rgb_t;

  typedef logic [PipeDepth-1:0] stage_en_t;

endpackage

### sv/mcc_lane.sv
module mcc_lane import mcc_pkg::*; #(
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                clk_i,
  input  stage_en_t           en_i,
  input  logic [SampleW-1:0]  sample_i,
  input  logic [2*SampleW-1:0] window_i,
  input  logic [ColorW-1:0]   color_i,
  output rgb_t                scaled_o
);

  localparam int W  = SAMPLE_BITS;
  localparam int NW = W + 8;

  // The user must keep window and color static while pixels are in flight; the lane does not enforce it.
  logic signed [W:0] lo, hi, range_s, diff;
  logic [W-1:0]      d_abs, n_abs;
  logic [NW-1:0]     num;
  logic              zero_c, sat_c;

  always_comb begin
    lo      = $signed({1'b0, window_i[W-1:0]});
    hi      = $signed({1'b0, window_i[SampleW+W-1:SampleW]});
    range_s = hi - lo;
    diff    = $signed({1'b0, sample_i[W-1:0]}) - lo;
    if (range_s == '0) begin
      d_abs = W'(1);
    end else if (range_s[W]) begin
      d_abs = W'(-range_s);
    end else begin
      d_abs = range_s[W-1:0];
    end
    n_abs  = diff[W] ? W'(-diff) : diff[W-1:0];
    num    = {n_abs, 8'd0} - NW'(n_abs);
    zero_c = (diff == '0) || (diff[W] != range_s[W]);
    sat_c  = num >= {d_abs, 8'd0};
  end

  logic [NW-1:0] r_q [0:8];
  logic [7:0]    q_q [0:8];
  logic          zero_q [0:8];
  logic          sat_q  [0:8];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]    <= num;
      q_q[0]    <= '0;
      zero_q[0] <= zero_c;
      sat_q[0]  <= sat_c;
    end
  end

  // One restoring quotient bit per stage, most significant first.
  for (genvar j = 1; j <= 8; j++) begin : g_div
    localparam int Sh = 8 - j;
    logic [NW-1:0] trial;
    logic          fit;
    assign trial = NW'(d_abs) << Sh;
    assign fit   = r_q[j-1] >= trial;
    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        r_q[j]    <= fit ? r_q[j-1] - trial : r_q[j-1];
        q_q[j]    <= {q_q[j-1][6:0], fit};
        zero_q[j] <= zero_q[j-1];
        sat_q[j]  <= sat_q[j-1];
      end
    end
  end

  logic [7:0]  inten;
  logic [15:0] prod_q [3];
  logic [15:0] tmp    [3];
  logic [7:0]  quo    [3];

  always_comb begin
    if (zero_q[8]) begin
      inten = '0;
    end else if (sat_q[8]) begin
      inten = 8'd255;
    end else begin
      inten = q_q[8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[9]) begin
      prod_q[0] <= color_i[23:16] * inten;
      prod_q[1] <= color_i[15:8]  * inten;
      prod_q[2] <= color_i[7:0]   * inten;
    end
  end

  // Exact floor(p / 255) for p below 65280.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tmp[k] = prod_q[k] + 16'd1 + {8'd0, prod_q[k][15:8]};
      quo[k] = tmp[k][15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[10]) begin
      scaled_o <= '{r: quo[0], g: quo[1], b: quo[2]};
    end
  end

endmodule

### sv/mcc_merge.sv
module mcc_merge import mcc_pkg::*; #(
  parameter int CHANNELS = ChannelsDef
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  rgb_t  lane_i [CHANNELS],
  output rgb_t  rgb_o
);

  logic [SumW-1:0] sr, sg, sb;

  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      sr = sr + SumW'(lane_i[c].r);
      sg = sg + SumW'(lane_i[c].g);
      sb = sb + SumW'(lane_i[c].b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_o.r <= (sr > SumW'(255)) ? 8'd255 : sr[7:0];
      rgb_o.g <= (sg > SumW'(255)) ? 8'd255 : sg[7:0];
      rgb_o.b <= (sb > SumW'(255)) ? 8'd255 : sb[7:0];
    end
  end

endmodule

### sv/multichannel_color_composite.sv
// Window-levels four 16-bit channel samples per pixel and adds each channel's
// color, scaled by its intensity, into a saturated RGB result. One pixel is
// taken every cycle while in_stall_o is low; a pixel passes through the
// prepare stage, the eight-stage quotient pipeline in each channel lane, and
// the product, scale and merge stages. Stalls hold the pipeline only
// where it is full, so bubbles are squeezed out. Write configuration only
// while no pixel is in flight.
module multichannel_color_composite import mcc_pkg::*; #(
  parameter int CHANNELS    = ChannelsDef,
  parameter int SAMPLE_BITS = SampleBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [WinW-1:0]     cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [SampleW-1:0]  sample_ch0_i,
  input  logic [SampleW-1:0]  sample_ch1_i,
  input  logic [SampleW-1:0]  sample_ch2_i,
  input  logic [SampleW-1:0]  sample_ch3_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CompW-1:0]    red_o,
  output logic [CompW-1:0]    green_o,
  output logic [CompW-1:0]    blue_o
);

  logic [ColorW-1:0] color_q [MaxChannels];
  logic [WinW-1:0]   win_q   [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < MaxChannels; c++) color_q[c] <= ColorReset;
      win_q[0] <= WinReset;
      win_q[1] <= WinReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        RegColorCh0:   color_q[0] <= cfg_wdata_i[ColorW-1:0];
        RegColorCh1:   color_q[1] <= cfg_wdata_i[ColorW-1:0];
        RegColorCh2:   color_q[2] <= cfg_wdata_i[ColorW-1:0];
        RegColorCh3:   color_q[3] <= cfg_wdata_i[ColorW-1:0];
        RegWindowCh01: win_q[0]   <= cfg_wdata_i;
        RegWindowCh23: win_q[1]   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance.
  logic [PipeDepth-1:0] v_q;
  stage_en_t            adv;

  always_comb begin
    adv[PipeDepth-1] = !v_q[PipeDepth-1] || !out_stall_i;
    for (int k = PipeDepth - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < PipeDepth; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = v_q[PipeDepth-1];

  logic [SampleW-1:0] sample [MaxChannels];
  assign sample[0] = sample_ch0_i;
  assign sample[1] = sample_ch1_i;
  assign sample[2] = sample_ch2_i;
  assign sample[3] = sample_ch3_i;

  rgb_t lane_rgb [CHANNELS];
  rgb_t rgb;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
    localparam int Lo = (c % 2) * 2 * SampleW;
    mcc_lane #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .en_i     (adv),
      .sample_i (sample[c]),
      .window_i (win_q[c/2][Lo +: 2*SampleW]),
      .color_i  (color_q[c]),
      .scaled_o (lane_rgb[c])
    );
  end

  mcc_merge #(
    .CHANNELS (CHANNELS)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (adv[PipeDepth-1]),
    .lane_i (lane_rgb),
    .rgb_o  (rgb)
  );

  assign red_o   = rgb.r;
  assign green_o = rgb.g;
  assign blue_o  = rgb.b;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output is free");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  a_transfer_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> v_q[0])
    else $error("accepted pixel lost at first stage");

endmodule
